FILE: rtl/core/ppg_pkg.sv
// ---------------------------------------------------------------------------
// ppg_pkg: shared constants and types of the pulse beat detector
// Field widths, reset values, register indexes and the request structs of the
// bit-serial divider and square root units.
// ---------------------------------------------------------------------------
`default_nettype none
package ppg_pkg;

   localparam int SMOOTH_TAPS_DEF   = 5;
   localparam int HISTORY_DEPTH_DEF = 10;

   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = 14;   // up to 16 taps of 10 bits
   localparam int IVL_W    = 12;
   localparam int TIME_W   = 32;
   localparam int TOT_W    = 16;   // up to 16 intervals of 12 bits
   localparam int SQ_W     = 28;   // up to 16 squares of 24 bits
   localparam int NUM_W    = 36;   // squares times 256
   localparam int DEN_W    = 16;
   localparam int ROOT_W   = NUM_W / 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [SAMPLE_W-1:0] THR_RESET   = 10'd550;
   localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 10'd512;
   localparam logic [IVL_W-1:0]    IVL_RESET   = 12'd600;
   localparam logic [DEN_W-1:0]    BPM_NUMER   = 16'd60000;
   localparam logic [7:0]          MS_RESET      = 8'd2;
   localparam logic [11:0]         GAP_RESET     = 12'd300;
   localparam logic [11:0]         TIMEOUT_RESET = 12'd2500;
   localparam logic [11:0]         JUMP_RESET    = 12'd300;
   localparam logic [9:0]          PNN_RESET     = 10'd50;

   // x / 5 == (x * 3277) >> 14 for every 12-bit x
   localparam logic [11:0] RECIP5    = 12'd3277;
   localparam int          RECIP5_SH = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PNN      = 3'd5;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] value;
   } sqrt_req_type;

endpackage
`default_nettype wire

FILE: rtl/core/ppg_div.sv
// ---------------------------------------------------------------------------
// ppg_div: bit-serial restoring divider
// One quotient bit per cycle, the dividend shifting out of the quotient
// register as the quotient shifts in.
// ---------------------------------------------------------------------------
`default_nettype none
module ppg_div (
   input  wire                       clock,
   input  wire                       reset,
   input  ppg_pkg::div_req_type      req,
   output logic                      done,
   output logic [ppg_pkg::NUM_W-1:0] quot
);
   import ppg_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial, diff;
   logic             fits;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            quot_ff <= req.num;
            rem_ff  <= '0;
            den_ff  <= req.den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[NUM_W-2:0], fits};
            rem_ff  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

FILE: rtl/core/ppg_sqrt.sv
// ---------------------------------------------------------------------------
// ppg_sqrt: digit-serial integer square root
// Restoring method, one root bit (two radicand bits) per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module ppg_sqrt (
   input  wire                        clock,
   input  wire                        reset,
   input  ppg_pkg::sqrt_req_type      req,
   output logic                       done,
   output logic [ppg_pkg::ROOT_W-1:0] root
);
   import ppg_pkg::*;

   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [NUM_W-1:0]  val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [REM_W+1:0]  part, trial, diff;
   logic              fits;

   assign part  = {rem_ff, val_ff[NUM_W-1 -: 2]};
   assign trial = (REM_W + 2)'({root_ff, 2'b01});
   assign diff  = part - trial;
   assign fits  = part >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            val_ff  <= req.value;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            val_ff  <= {val_ff[NUM_W-3:0], 2'b00};
            rem_ff  <= fits ? diff[REM_W-1:0] : part[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

FILE: rtl/core/ppg_beat_detector_hrv.sv
// ---------------------------------------------------------------------------
// ppg_beat_detector_hrv: pulse beat detector with time-domain HRV statistics
// Smooths samples, tracks an adaptive threshold, detects beats and keeps
// BPM, SDNN, RMSSD and the pNN50 count over an interval history.
// ---------------------------------------------------------------------------
// One sample is worked on at a time. A sample that gives no accepted beat
// passes through the bit-serial divide of the moving-average sum, the beat
// decision and the output stage. A sample that gives an accepted beat adds
// the statistics pass: two rotations of the interval history, three or four
// more divides (the BPM divide is skipped when the mean interval is zero)
// and two square roots. A new sample is taken while the previous result
// still waits in the output register. Configuration writes are always taken.
`default_nettype none
module ppg_beat_detector_hrv #(
   parameter int SMOOTH_TAPS   = ppg_pkg::SMOOTH_TAPS_DEF,
   parameter int HISTORY_DEPTH = ppg_pkg::HISTORY_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [9:0]  req_raw_sample,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [9:0]  rsp_smoothed_signal,
   output logic        rsp_beat_valid,
   output logic        rsp_pulse_high,
   output logic [7:0]  rsp_beats_per_minute,
   output logic [11:0] rsp_beat_interval_ms,
   output logic [15:0] rsp_sdnn_x16,
   output logic [15:0] rsp_rmssd_x16,
   output logic [3:0]  rsp_pnn50_count,
   output logic [9:0]  rsp_threshold,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [ppg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [ppg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppg_pkg::*;

   localparam int CNT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SMOOTH, ST_DECIDE, ST_ROT1, ST_MEAN, ST_BPM, ST_ROT2,
      ST_SDDIV, ST_SDSQ, ST_RMDIV, ST_RMSQ, ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [9:0]  init_thr_ff, pnn_cfg_ff;
   logic [7:0]  ms_cfg_ff;
   logic [11:0] gap_cfg_ff, timeout_cfg_ff, jump_cfg_ff;

   // beat state
   logic [SAMPLE_W-1:0] win_ff [SMOOTH_TAPS];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [TIME_W-1:0]   time_ff, last_ff, time_in;
   logic [IVL_W-1:0]    hist_ff [HISTORY_DEPTH];
   logic [IVL_W-1:0]    ivl_ff;
   logic [SAMPLE_W-1:0] peak_ff, trough_ff, thr_ff, sig_ff;
   logic                pulse_ff, first_ff, second_ff, beat_ff;
   logic [7:0]          bpm_ff;
   logic [15:0]         sdnn_ff, rmssd_ff;
   logic [3:0]          pnn_ff;

   // statistics pass
   logic [CNT_W-1:0] cnt_ff;
   logic [TOT_W-1:0] total_ff;
   logic [SQ_W-1:0]  sd_ff, sq_ff;
   logic [IVL_W-1:0] prev_ff, mean_ff;
   logic [3:0]       pcnt_ff;
   logic [IVL_W-1:0] head, d1, d2, mul_a;
   logic [2*IVL_W-1:0] mul_p;

   // output register
   logic                rsp_valid_ff, rsp_valid_in, emit_fire;
   logic [SAMPLE_W-1:0] o_sig_ff, o_thr_ff;
   logic                o_beat_ff, o_pulse_ff;
   logic [7:0]          o_bpm_ff;
   logic [IVL_W-1:0]    o_ivl_ff;
   logic [15:0]         o_sdnn_ff, o_rmssd_ff;
   logic [3:0]          o_pnn_ff;

   // serial units
   div_req_type        div_req_ff;
   sqrt_req_type       sq_req_ff;
   logic               div_done, sq_done;
   logic               div_start_in, sq_start_in;
   logic [NUM_W-1:0]   div_quot;
   logic [ROOT_W-1:0]  sq_root;
   logic [15:0]        root_sat;

   ppg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   ppg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign root_sat = (|sq_root[ROOT_W-1:16]) ? 16'hFFFF : sq_root[15:0];

   // ---------------- per-sample decision ----------------
   logic [TIME_W-1:0]   n_ms;
   logic [2*IVL_W-1:0]  q5_prod;
   logic [IVL_W-1:0]    gap35;
   logic                below, above, beat, past_gap;
   logic [SAMPLE_W-1:0] peak_in, trough_in, thr_in;
   logic                pulse_in, first_in, second_in, acc_in, clr_in, skip;
   logic [IVL_W-1:0]    ivl_in, newest, jump;
   logic [TIME_W-1:0]   last_in;
   logic [IVL_W-1:0]    hist_in [HISTORY_DEPTH];
   logic signed [11:0]  amp, half, tt;

   assign n_ms     = time_ff - last_ff;
   assign q5_prod  = ivl_ff * RECIP5;
   assign gap35    = IVL_W'(q5_prod[RECIP5_SH +: 10]) * IVL_W'(3);
   assign past_gap = n_ms > TIME_W'(gap35);
   assign below    = sig_ff < thr_ff;
   assign above    = sig_ff > thr_ff;
   assign beat     = (n_ms > TIME_W'(gap_cfg_ff)) && above && !pulse_ff && past_gap;

   always_comb begin
      peak_in   = peak_ff;
      trough_in = trough_ff;
      thr_in    = thr_ff;
      pulse_in  = pulse_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ivl_in    = ivl_ff;
      last_in   = last_ff;
      hist_in   = hist_ff;
      acc_in    = 1'b0;
      clr_in    = 1'b0;
      skip      = 1'b0;
      newest    = '0;
      jump      = '0;
      amp       = '0;
      half      = '0;
      tt        = '0;
      if (below && past_gap && (sig_ff < trough_ff)) trough_in = sig_ff;
      if (above && (sig_ff > peak_ff)) peak_in = sig_ff;
      if (beat) begin
         pulse_in = 1'b1;
         ivl_in   = (|n_ms[TIME_W-1:IVL_W]) ? {IVL_W{1'b1}} : n_ms[IVL_W-1:0];
         last_in  = time_ff;
         if (second_ff) begin
            second_in = 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) hist_in[i] = ivl_in;
         end
         if (first_ff) begin
            // first beat is only a time mark
            first_in  = 1'b0;
            second_in = 1'b1;
            skip      = 1'b1;
         end else begin
            newest = hist_in[HISTORY_DEPTH-1];
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_in[i] = hist_in[i+1];
            jump = (ivl_in > newest) ? ivl_in - newest : newest - ivl_in;
            if (jump <= jump_cfg_ff) begin
               hist_in[HISTORY_DEPTH-1] = ivl_in;
               acc_in = 1'b1;
            end
         end
      end
      if (!skip) begin
         if (below && pulse_in) begin
            amp  = $signed({2'b00, peak_in}) - $signed({2'b00, trough_in});
            half = (amp + (amp[11] ? 12'sd1 : 12'sd0)) >>> 1;
            tt   = half + $signed({2'b00, trough_in});
            if (tt[11]) thr_in = '0;
            else if (tt > 12'sd1023) thr_in = {SAMPLE_W{1'b1}};
            else thr_in = tt[SAMPLE_W-1:0];
            pulse_in  = 1'b0;
            peak_in   = thr_in;
            trough_in = thr_in;
         end
         if (n_ms > TIME_W'(timeout_cfg_ff)) begin
            thr_in    = init_thr_ff;
            last_in   = time_ff;
            peak_in   = LEVEL_RESET;
            trough_in = LEVEL_RESET;
            pulse_in  = 1'b0;
            first_in  = 1'b1;
            second_in = 1'b0;
            ivl_in    = IVL_RESET;
            acc_in    = 1'b0;
            clr_in    = 1'b1;
         end
      end
   end

   // ---------------- statistics datapath ----------------
   assign head  = hist_ff[0];
   assign d1    = (head > prev_ff) ? head - prev_ff : prev_ff - head;
   assign d2    = (mean_ff > head) ? mean_ff - head : head - mean_ff;
   assign mul_a = (state_ff == ST_ROT2) ? d2 : d1;
   assign mul_p = mul_a * mul_a;

   assign sum_in  = sum_ff + SUM_W'(req_raw_sample) - SUM_W'(win_ff[SMOOTH_TAPS-1]);
   assign time_in = time_ff + TIME_W'(ms_cfg_ff);

   // start pulses of the serial units
   assign div_start_in = ((state_ff == ST_IDLE) && req_valid) ||
                         (((state_ff == ST_ROT1) || (state_ff == ST_ROT2)) &&
                          (cnt_ff == CNT_W'(HISTORY_DEPTH - 1))) ||
                         ((state_ff == ST_MEAN) && div_done &&
                          (div_quot[IVL_W-1:0] != '0)) ||
                         ((state_ff == ST_SDSQ) && sq_done);
   assign sq_start_in  = ((state_ff == ST_SDDIV) || (state_ff == ST_RMDIV)) && div_done;

   assign emit_fire    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         init_thr_ff    <= THR_RESET;
         ms_cfg_ff      <= MS_RESET;
         gap_cfg_ff     <= GAP_RESET;
         timeout_cfg_ff <= TIMEOUT_RESET;
         jump_cfg_ff    <= JUMP_RESET;
         pnn_cfg_ff     <= PNN_RESET;
         for (int i = 0; i < SMOOTH_TAPS; i++) win_ff[i] <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         sum_ff       <= '0;
         time_ff      <= '0;
         last_ff      <= '0;
         ivl_ff       <= IVL_RESET;
         peak_ff      <= LEVEL_RESET;
         trough_ff    <= LEVEL_RESET;
         thr_ff       <= THR_RESET;
         pulse_ff     <= 1'b0;
         first_ff     <= 1'b1;
         second_ff    <= 1'b0;
         bpm_ff       <= '0;
         sdnn_ff      <= '0;
         rmssd_ff     <= '0;
         pnn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
         sq_req_ff    <= '0;
      end else begin
         div_req_ff.start <= div_start_in;
         sq_req_ff.start  <= sq_start_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INIT_THR: init_thr_ff    <= csr_wdata[9:0];
               CSR_MS:       ms_cfg_ff      <= csr_wdata[7:0];
               CSR_MIN_GAP:  gap_cfg_ff     <= csr_wdata;
               CSR_TIMEOUT:  timeout_cfg_ff <= csr_wdata;
               CSR_JUMP:     jump_cfg_ff    <= csr_wdata;
               CSR_PNN:      pnn_cfg_ff     <= csr_wdata[9:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  win_ff[0] <= req_raw_sample;
                  for (int i = 1; i < SMOOTH_TAPS; i++) win_ff[i] <= win_ff[i-1];
                  sum_ff         <= sum_in;
                  time_ff        <= time_in;
                  div_req_ff.num <= NUM_W'(sum_in);
                  div_req_ff.den <= DEN_W'(SMOOTH_TAPS);
                  state_ff       <= ST_SMOOTH;
               end
            end
            ST_SMOOTH: begin
               if (div_done) begin
                  sig_ff   <= div_quot[SAMPLE_W-1:0];
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               peak_ff   <= peak_in;
               trough_ff <= trough_in;
               thr_ff    <= thr_in;
               pulse_ff  <= pulse_in;
               first_ff  <= first_in;
               second_ff <= second_in;
               ivl_ff    <= ivl_in;
               last_ff   <= last_in;
               hist_ff   <= hist_in;
               beat_ff   <= acc_in;
               if (clr_in) begin
                  bpm_ff   <= '0;
                  sdnn_ff  <= '0;
                  rmssd_ff <= '0;
                  pnn_ff   <= '0;
               end
               cnt_ff   <= '0;
               total_ff <= '0;
               sd_ff    <= '0;
               sq_ff    <= '0;
               pcnt_ff  <= '0;
               prev_ff  <= '0;
               state_ff <= acc_in ? ST_ROT1 : ST_EMIT;
            end
            ST_ROT1: begin
               // rotate history once, summing and taking successive differences
               for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_ff[i] <= hist_ff[i+1];
               hist_ff[HISTORY_DEPTH-1] <= head;
               total_ff <= total_ff + TOT_W'(head);
               prev_ff  <= head;
               if (cnt_ff != '0) begin
                  sd_ff <= sd_ff + SQ_W'(mul_p);
                  if (d1 > IVL_W'(pnn_cfg_ff)) pcnt_ff <= pcnt_ff + 1'b1;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(HISTORY_DEPTH - 1)) begin
                  div_req_ff.num <= NUM_W'(total_ff + TOT_W'(head));
                  div_req_ff.den <= DEN_W'(HISTORY_DEPTH);
                  state_ff       <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               if (div_done) begin
                  mean_ff <= div_quot[IVL_W-1:0];
                  cnt_ff  <= '0;
                  if (div_quot[IVL_W-1:0] == '0) begin
                     bpm_ff   <= 8'hFF;
                     state_ff <= ST_ROT2;
                  end else begin
                     div_req_ff.num <= NUM_W'(BPM_NUMER);
                     div_req_ff.den <= DEN_W'(div_quot[IVL_W-1:0]);
                     state_ff       <= ST_BPM;
                  end
               end
            end
            ST_BPM: begin
               if (div_done) begin
                  bpm_ff   <= (|div_quot[NUM_W-1:8]) ? 8'hFF : div_quot[7:0];
                  state_ff <= ST_ROT2;
               end
            end
            ST_ROT2: begin
               for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_ff[i] <= hist_ff[i+1];
               hist_ff[HISTORY_DEPTH-1] <= head;
               sq_ff  <= sq_ff + SQ_W'(mul_p);
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(HISTORY_DEPTH - 1)) begin
                  div_req_ff.num <= {sq_ff + SQ_W'(mul_p), 8'h00};
                  div_req_ff.den <= DEN_W'(HISTORY_DEPTH);
                  state_ff       <= ST_SDDIV;
               end
            end
            ST_SDDIV: begin
               if (div_done) begin
                  sq_req_ff.value <= div_quot;
                  state_ff        <= ST_SDSQ;
               end
            end
            ST_SDSQ: begin
               if (sq_done) begin
                  sdnn_ff        <= root_sat;
                  div_req_ff.num <= {sd_ff, 8'h00};
                  div_req_ff.den <= DEN_W'(HISTORY_DEPTH - 1);
                  state_ff       <= ST_RMDIV;
               end
            end
            ST_RMDIV: begin
               if (div_done) begin
                  sq_req_ff.value <= div_quot;
                  state_ff        <= ST_RMSQ;
               end
            end
            ST_RMSQ: begin
               if (sq_done) begin
                  rmssd_ff <= root_sat;
                  pnn_ff   <= pcnt_ff;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  o_sig_ff     <= sig_ff;
                  o_beat_ff    <= beat_ff;
                  o_pulse_ff   <= pulse_ff;
                  o_bpm_ff     <= bpm_ff;
                  o_ivl_ff     <= ivl_ff;
                  o_sdnn_ff    <= sdnn_ff;
                  o_rmssd_ff   <= rmssd_ff;
                  o_pnn_ff     <= pnn_ff;
                  o_thr_ff     <= thr_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_smoothed_signal  = o_sig_ff;
   assign rsp_beat_valid       = o_beat_ff;
   assign rsp_pulse_high       = o_pulse_ff;
   assign rsp_beats_per_minute = o_bpm_ff;
   assign rsp_beat_interval_ms = o_ivl_ff;
   assign rsp_sdnn_x16         = o_sdnn_ff;
   assign rsp_rmssd_x16        = o_rmssd_ff;
   assign rsp_pnn50_count      = o_pnn_ff;
   assign rsp_threshold        = o_thr_ff;

`ifndef SYNTHESIS
   // an accepted beat always leaves the detector inside the pulse
   a_beat_in_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat_valid |-> rsp_pulse_high)
      else $error("beat reported outside a pulse");

   // pair count never exceeds the number of successive pairs
   a_pnn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pnn50_count <= 4'(HISTORY_DEPTH - 1))
      else $error("pnn50 count out of range");

   // divider finishes only while a divide is awaited
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SMOOTH || state_ff == ST_MEAN ||
                    state_ff == ST_BPM || state_ff == ST_SDDIV ||
                    state_ff == ST_RMDIV))
      else $error("unexpected divider completion");

   // square root finishes only while a root is awaited
   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SDSQ || state_ff == ST_RMSQ))
      else $error("unexpected square root completion");
`endif

endmodule
`default_nettype wire

FILE: dv/ppg_beat_detector_hrv_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppg_beat_detector_hrv_tb: self-checking bench for the pulse beat detector
// Drives pulse-like sample trains and noise through several register settings
// and idling patterns. Every result beat is compared field by field against a
// behavioral predictor of smoothing, beat detection and HRV statistics, or against its pinned result for pinned rows.
// ---------------------------------------------------------------------------
module ppg_beat_detector_hrv_tb;
   import ppg_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [9:0]  smoothed;
      logic        beat;
      logic        pulse;
      logic [7:0]  bpm;
      logic [11:0] ivl;
      logic [15:0] sdnn;
      logic [15:0] rmssd;
      logic [3:0]  pnn;
      logic [9:0]  thr;
   } beat_result_t;

   typedef struct {
      logic [9:0]   sample;
      bit           pinned;
      beat_result_t pinned_result;
   } sample_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [9:0]  req_raw_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [9:0]  rsp_smoothed_signal;
   logic        rsp_beat_valid;
   logic        rsp_pulse_high;
   logic [7:0]  rsp_beats_per_minute;
   logic [11:0] rsp_beat_interval_ms;
   logic [15:0] rsp_sdnn_x16;
   logic [15:0] rsp_rmssd_x16;
   logic [3:0]  rsp_pnn50_count;
   logic [9:0]  rsp_threshold;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ppg_beat_detector_hrv DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state and register copies
   logic [9:0]  cfg_init_thr;
   logic [7:0]  cfg_ms;
   logic [11:0] cfg_min_gap, cfg_timeout, cfg_jump;
   logic [9:0]  cfg_pnn;
   logic [9:0]  win [SMOOTH_TAPS_DEF];
   int          win_idx;
   logic [31:0] now_ms, last_ms;
   logic [11:0] ivl_hist [HISTORY_DEPTH_DEF];
   logic [11:0] ivl_now;
   int          peak, trough, thr;
   bit          in_pulse, first_beat, second_beat;
   logic [7:0]  h_bpm;
   logic [15:0] h_sdnn, h_rmssd;
   logic [3:0]  h_pnn;

   beat_result_t expected_results[$];
   int  fail_count = 0;
   int  results_seen = 0;
   int  beats_seen = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic void clear_beat_state();
      peak = int'(LEVEL_RESET);
      trough = int'(LEVEL_RESET);
      in_pulse = 0;
      first_beat = 1;
      second_beat = 0;
      ivl_now = IVL_RESET;
      h_bpm = '0;
      h_sdnn = '0;
      h_rmssd = '0;
      h_pnn = '0;
   endfunction

   function automatic void predictor_reset();
      cfg_init_thr = THR_RESET;
      cfg_ms = MS_RESET;
      cfg_min_gap = GAP_RESET;
      cfg_timeout = TIMEOUT_RESET;
      cfg_jump = JUMP_RESET;
      cfg_pnn = PNN_RESET;
      foreach (win[i]) win[i] = '0;
      win_idx = 0;
      now_ms = '0;
      last_ms = '0;
      foreach (ivl_hist[i]) ivl_hist[i] = '0;
      thr = int'(THR_RESET);
      clear_beat_state();
   endfunction

   function automatic void predictor_config(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_INIT_THR: cfg_init_thr = val[9:0];
         CSR_MS:       cfg_ms = val[7:0];
         CSR_MIN_GAP:  cfg_min_gap = val;
         CSR_TIMEOUT:  cfg_timeout = val;
         CSR_JUMP:     cfg_jump = val;
         CSR_PNN:      cfg_pnn = val[9:0];
         default: ;
      endcase
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] clip16(longint unsigned v);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic void update_hrv_stats();
      longint total = 0;
      longint mean, d;
      longint unsigned sq = 0, sd = 0;
      int cnt = 0;
      foreach (ivl_hist[i]) total += longint'(ivl_hist[i]);
      mean = total / HISTORY_DEPTH_DEF;
      if (mean == 0) h_bpm = 8'd255;
      else h_bpm = (60000 / mean > 255) ? 8'd255 : 8'(60000 / mean);
      foreach (ivl_hist[i]) begin
         d = mean - longint'(ivl_hist[i]);
         sq += d * d;
      end
      for (int i = 1; i < HISTORY_DEPTH_DEF; i++) begin
         d = longint'(ivl_hist[i]) - longint'(ivl_hist[i-1]);
         if (d < 0) d = -d;
         sd += d * d;
         if (d > longint'(cfg_pnn)) cnt++;
      end
      h_sdnn = clip16(int_sqrt(sq * 256 / HISTORY_DEPTH_DEF));
      h_rmssd = clip16(int_sqrt(sd * 256 / (HISTORY_DEPTH_DEF - 1)));
      h_pnn = 4'(cnt);
   endfunction

   function automatic beat_result_t predict_sample(logic [9:0] raw);
      beat_result_t r;
      int sum = 0;
      int sig, amp, t;
      logic [31:0] n, gap35;
      logic [11:0] newest, diff;
      bit beat = 0;
      bit skip_rest = 0;
      win[win_idx] = raw;
      win_idx = (win_idx + 1) % SMOOTH_TAPS_DEF;
      foreach (win[i]) sum += int'(win[i]);
      sig = sum / SMOOTH_TAPS_DEF;
      now_ms += 32'(cfg_ms);
      n = now_ms - last_ms;
      gap35 = 32'(ivl_now / 12'd5) * 32'd3;
      if (sig < thr && n > gap35 && sig < trough) trough = sig;
      if (sig > thr && sig > peak) peak = sig;
      if (n > cfg_min_gap && sig > thr && !in_pulse && n > gap35) begin
         in_pulse = 1;
         ivl_now = (n > 4095) ? 12'd4095 : n[11:0];
         last_ms = now_ms;
         if (second_beat) begin
            second_beat = 0;
            foreach (ivl_hist[i]) ivl_hist[i] = ivl_now;
         end
         if (first_beat) begin
            // first beat after reset or timeout only arms the history
            first_beat = 0;
            second_beat = 1;
            skip_rest = 1;
         end else begin
            for (int i = 0; i < HISTORY_DEPTH_DEF - 1; i++) ivl_hist[i] = ivl_hist[i+1];
            newest = ivl_hist[HISTORY_DEPTH_DEF-1];
            diff = (ivl_now > newest) ? ivl_now - newest : newest - ivl_now;
            if (diff <= cfg_jump) begin
               ivl_hist[HISTORY_DEPTH_DEF-1] = ivl_now;
               update_hrv_stats();
               beat = 1;
            end
         end
      end
      if (!skip_rest) begin
         if (sig < thr && in_pulse) begin
            amp = peak - trough;
            t = amp / 2 + trough;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
            in_pulse = 0;
            thr = t;
            peak = t;
            trough = t;
         end
         if (n > cfg_timeout) begin
            thr = int'(cfg_init_thr);
            last_ms = now_ms;
            clear_beat_state();
            beat = 0;
         end
      end
      r.smoothed = sig[9:0];
      r.beat = beat;
      r.pulse = in_pulse;
      r.bpm = h_bpm;
      r.ivl = ivl_now;
      r.sdnn = h_sdnn;
      r.rmssd = h_rmssd;
      r.pnn = h_pnn;
      r.thr = thr[9:0];
      return r;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_sample(logic [9:0] s, bit pinned = 0,
                              beat_result_t pinned_result = '0);
      beat_result_t r;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_raw_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_sample(s);
      expected_results.push_back(pinned ? pinned_result : r);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predictor_config(idx, val);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int init_thr, int ms, int gap, int tmo, int jump, int pnn);
      drain();
      write_reg(CSR_INIT_THR, CSR_DATA_W'(init_thr));
      write_reg(CSR_MS, CSR_DATA_W'(ms));
      write_reg(CSR_MIN_GAP, CSR_DATA_W'(gap));
      write_reg(CSR_TIMEOUT, CSR_DATA_W'(tmo));
      write_reg(CSR_JUMP, CSR_DATA_W'(jump));
      write_reg(CSR_PNN, CSR_DATA_W'(pnn));
      csr_valid <= 0;
   endtask

   // pulse trains with random shape; some noise, odd periods and flat gaps
   task automatic pulse_trains(int n_items, int pmin, int pmax, int flat_len);
      int sent = 0;
      int per, w, hi, lo, kind;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         per = $urandom_range(pmin, pmax);
         if (kind < 10) per = per * 2 + $urandom_range(3);
         w = $urandom_range(2, 5);
         hi = $urandom_range(650, 1023);
         lo = $urandom_range(0, 300);
         if (kind >= 90) begin
            for (int k = 0; k < per; k++) send_sample(10'($urandom_range(1023)));
            sent += per;
         end else if (kind >= 86) begin
            for (int k = 0; k < flat_len; k++) send_sample(10'(lo));
            sent += flat_len;
         end else begin
            for (int k = 0; k < per; k++)
               send_sample(k < w ? 10'(hi - int'($urandom_range(40)))
                                 : 10'(lo + int'($urandom_range(60))));
            sent += per;
         end
      end
   endtask

   always @(posedge clock) begin
      if (recv_stall_pct > 0) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      else rsp_ready <= 1;
   end

   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fail_count++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      beat_result_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no expectation pending");
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            results_seen++;
            if (rsp_beat_valid) beats_seen++;
            check_field("smoothed_signal", e.smoothed, rsp_smoothed_signal);
            check_field("beat_valid", e.beat, rsp_beat_valid);
            check_field("pulse_high", e.pulse, rsp_pulse_high);
            check_field("beats_per_minute", e.bpm, rsp_beats_per_minute);
            check_field("beat_interval_ms", e.ivl, rsp_beat_interval_ms);
            check_field("sdnn_x16", e.sdnn, rsp_sdnn_x16);
            check_field("rmssd_x16", e.rmssd, rsp_rmssd_x16);
            check_field("pnn50_count", e.pnn, rsp_pnn50_count);
            check_field("threshold", e.thr, rsp_threshold);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", expected_results.size());
         $display("ppg_beat_detector_hrv: mismatch");
         $finish;
      end
   end

   sample_row_t directed_rows[$];

   initial begin
      sample_row_t row;
      logic [9:0] pattern [15];
      predictor_reset();
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: field extremes and bit patterns at reset settings
      row = '{sample: 10'd0, pinned: 1,
              pinned_result: '{10'd0, 1'b0, 1'b0, 8'd0, 12'd600, 16'd0, 16'd0, 4'd0, 10'd550}};
      directed_rows.push_back(row);
      row = '{sample: 10'd1023, pinned: 1,
              pinned_result: '{10'd204, 1'b0, 1'b0, 8'd0, 12'd600, 16'd0, 16'd0, 4'd0, 10'd550}};
      directed_rows.push_back(row);
      pattern = '{10'd1023, 10'd1023, 10'd1023, 10'h155, 10'h2AA,
                  10'h155, 10'h2AA, 10'd0, 10'd0, 10'd0, 10'd0,
                  10'd0, 10'd1, 10'd512, 10'd1022};
      foreach (pattern[i]) directed_rows.push_back('{pattern[i], 0, '0});
      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].pinned,
                     directed_rows[i].pinned_result);

      // large millisecond step per sample so beats and the interval history fill quickly
      configure(550, 40, 300, 2500, 300, 50);
      pulse_trains(110, 12, 30, 70);

      send_idle_pct = 55;
      configure(400, 20, 250, 3000, 200, 20);
      pulse_trains(90, 20, 45, 160);

      // extremes: no gap, widest limits, zero threshold
      send_idle_pct = 0;
      recv_stall_pct = 55;
      configure(0, 255, 0, 4095, 4095, 0);
      pulse_trains(90, 3, 15, 20);

      // opposite extremes: timeout on every sample
      send_idle_pct = 18;
      recv_stall_pct = 18;
      configure(1023, 1, 4095, 0, 0, 1023);
      pulse_trains(40, 4, 12, 10);

      // mixed settings plus writes to unused indexes, which must be ignored
      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure(600, 8, 200, 1500, 100, 30);
      write_reg(3'd6, 12'hFFF);
      write_reg(3'd7, 12'h0A5);
      csr_valid <= 0;
      pulse_trains(190, 40, 90, 200);

      drain();
      $display("covered %0d samples over six register settings and four idling mixes",
               results_seen);
      $display("accepted beats with new statistics: %0d", beats_seen);
      if (fail_count == 0) begin
         $display("ppg_beat_detector_hrv: match");
      end else begin
         $display("ppg_beat_detector_hrv: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ppg_pkg.sv
rtl/core/ppg_div.sv
rtl/core/ppg_sqrt.sv
rtl/core/ppg_beat_detector_hrv.sv
dv/ppg_beat_detector_hrv_tb.sv
